/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on clk, off while rst is high.
`define ASSERT_IMPLIES(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Invariant check, sampled on clk, off while rst is high.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
// Package for the first fit block allocator: codes, defaults and FSM states.
package ffba_pkg;

  localparam int CAPACITY_BYTES_DEF = 65536;
  localparam int HEADER_BYTES_DEF   = 16;

  localparam int REQ_W  = 17;
  localparam int ADDR_W = 16;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_NOT_USE = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_HDR     = 8'b0000_0100,
    S_RUN     = 8'b0000_1000,
    S_SPLIT   = 8'b0001_0000,
    S_COMMIT  = 8'b0010_0000,
    S_RELEASE = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } fsm_t;

endpackage

/* hw/rtl/ffba_hdr_mem.sv */
// Header store: single port write, single port read, registered read data.
module ffba_hdr_mem #(
  parameter int AW = 16,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// Top level: request sequencer walking block headers in the header store.
//
//  channel | dir | fields (tdata from bit 0)
//  s_*     | in  | action[1:0] req_size[18:2] block_addr[34:19]
//  m_*     | out | grant_addr[15:0] status[17:16] moved[18] copy_length[35:19]
//
// After rst a clearing pass writes header entries 0 to CAPACITY_BYTES-1, with
// s_tready low. Each request then passes through accept, a header check (free
// and resize only), a walk over the block headers (one header store read per
// cycle) and the result; a resize that moves walks twice. Up to three header
// writes (split, commit, release) may follow a walk. A finished result waits in
// the output register while the next request is accepted; the sequencer stalls
// only if it finishes again before that result is taken.
`include "assert_macros.svh"
module first_fit_block_allocator #(
  parameter int CAPACITY_BYTES = ffba_pkg::CAPACITY_BYTES_DEF,
  parameter int HEADER_BYTES   = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action, req_size, block_addr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // grant_addr, status, moved, copy_length
);
  import ffba_pkg::*;

  localparam int AW  = $clog2(CAPACITY_BYTES);
  localparam int SZW = AW + 1;
  localparam int WW  = ((AW > REQ_W) ? AW : REQ_W) + 3;
  localparam logic [WW-1:0] HDR_W = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] CAP_W = WW'(CAPACITY_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY_BYTES - 1);

  fsm_t state, state_next;
  logic mode_rsz, mode_rsz_next;
  action_t act, act_next;
  logic [REQ_W-1:0]  req, req_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [WW-1:0] need, need_next, off, off_next, cur, cur_next, sum, sum_next;
  logic [SZW-1:0] old, old_next;
  logic [AW-1:0] hdr, hdr_next, clr, clr_next;
  logic do_split, do_split_next;
  logic [WW-1:0] split_addr, split_addr_next, commit_addr, commit_addr_next;
  logic [SZW-1:0] split_size, split_size_next, commit_size, commit_size_next;
  logic [ADDR_W-1:0] res_grant, res_grant_next;
  status_t res_status, res_status_next;
  logic res_moved, res_moved_next;
  logic [REQ_W-1:0] res_copy, res_copy_next;
  logic out_load;

  logic re, we;
  logic [AW-1:0] raddr, waddr;
  logic [SZW:0] rdata, wdata;

  // input unpack
  logic [1:0] in_action;
  logic [REQ_W-1:0] in_req;
  logic [ADDR_W-1:0] in_addr;
  assign in_action = s_tdata[1:0];
  assign in_req    = s_tdata[18:2];
  assign in_addr   = s_tdata[34:19];
  assign s_tready  = (state == S_IDLE);

  ffba_hdr_mem #(.AW(AW), .DW(SZW + 1)) u_mem (
    .clk(clk), .re(re), .raddr(raddr), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  // walk arithmetic
  logic d_used;
  logic [WW-1:0] d_size, span, total, in_hdr, nxt, req_w;
  assign d_used = rdata[SZW];
  assign d_size = WW'(rdata[SZW-1:0]);
  assign span   = HDR_W + d_size;
  assign total  = WW'(old) + sum;
  assign in_hdr = WW'(in_addr) - HDR_W;
  assign req_w  = WW'(req);
  assign nxt    = (sum == '0) ? (off + HDR_W + d_size) : cur;

  // sequencer
  always_comb begin
    state_next = state;
    mode_rsz_next = mode_rsz;
    act_next = act;
    req_next = req;
    addr_next = addr;
    need_next = need;
    off_next = off;
    cur_next = cur;
    sum_next = sum;
    old_next = old;
    hdr_next = hdr;
    clr_next = clr;
    do_split_next = do_split;
    split_addr_next = split_addr;
    split_size_next = split_size;
    commit_addr_next = commit_addr;
    commit_size_next = commit_size;
    res_grant_next = res_grant;
    res_status_next = res_status;
    res_moved_next = res_moved;
    res_copy_next = res_copy;
    out_load = 1'b0;
    re = 1'b0;
    raddr = cur_next[AW-1:0];
    we = 1'b0;
    waddr = clr;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = (clr == '0) ? {1'b0, SZW'(CAPACITY_BYTES - HEADER_BYTES)} : '0;
        clr_next = clr + AW'(1);
        if (clr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          act_next = action_t'(in_action);
          req_next = in_req;
          addr_next = in_addr;
          hdr_next = in_hdr[AW-1:0];
          res_grant_next = '0;
          res_status_next = ST_OK;
          res_moved_next = 1'b0;
          res_copy_next = '0;
          case (in_action)
            ACT_ALLOC: begin
              mode_rsz_next = 1'b0;
              need_next = HDR_W + WW'(in_req);
              off_next = '0;
              cur_next = '0;
              sum_next = '0;
              re = 1'b1;
              raddr = '0;
              state_next = S_RUN;
            end
            ACT_FREE, ACT_RESIZE: begin
              if (WW'(in_addr) < HDR_W || in_hdr >= CAP_W) begin
                res_status_next = ST_NOT_USE;
                state_next = S_DONE;
              end else begin
                re = 1'b1;
                raddr = in_hdr[AW-1:0];
                state_next = S_HDR;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_HDR: begin
        if (!d_used) begin
          res_status_next = ST_NOT_USE;
          state_next = S_DONE;
        end else if (act == ACT_FREE) begin
          we = 1'b1;
          waddr = hdr;
          wdata = {1'b0, rdata[SZW-1:0]};
          state_next = S_DONE;
        end else begin
          old_next = rdata[SZW-1:0];
          mode_rsz_next = 1'b1;
          cur_next = WW'(addr) + d_size;
          sum_next = '0;
          re = (cur_next < CAP_W);
          raddr = cur_next[AW-1:0];
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cur < CAP_W && !d_used) begin
          // extend the free run
          sum_next = sum + span;
          cur_next = cur + span;
          re = (cur_next < CAP_W);
          raddr = cur_next[AW-1:0];
        end else if (!mode_rsz) begin
          if (sum >= need) begin
            do_split_next = (sum - need) > HDR_W;
            split_addr_next = off + need;
            split_size_next = SZW'(sum - need - HDR_W);
            commit_addr_next = off;
            commit_size_next = do_split_next ? SZW'(req_w) : SZW'(sum - HDR_W);
            res_grant_next = ADDR_W'(off + HDR_W);
            if (act == ACT_RESIZE) begin
              res_moved_next = 1'b1;
              res_copy_next = REQ_W'(old);
            end
            state_next = do_split_next ? S_SPLIT : S_COMMIT;
          end else if (nxt >= CAP_W) begin
            res_status_next = ST_NO_MEM;
            state_next = S_DONE;
          end else begin
            off_next = nxt;
            cur_next = nxt;
            sum_next = '0;
            re = 1'b1;
            raddr = nxt[AW-1:0];
          end
        end else if (total >= req_w) begin
          // resize in place
          do_split_next = (total - req_w) > HDR_W;
          split_addr_next = WW'(addr) + req_w;
          split_size_next = SZW'(total - req_w - HDR_W);
          commit_addr_next = WW'(hdr);
          commit_size_next = do_split_next ? SZW'(req_w) : SZW'(total);
          res_grant_next = addr;
          state_next = do_split_next ? S_SPLIT : S_COMMIT;
        end else begin
          // fall back to a fresh first fit walk
          mode_rsz_next = 1'b0;
          need_next = HDR_W + req_w;
          off_next = '0;
          cur_next = '0;
          sum_next = '0;
          re = 1'b1;
          raddr = '0;
        end
      end
      S_SPLIT: begin
        we = (split_addr < CAP_W);
        waddr = split_addr[AW-1:0];
        wdata = {1'b0, split_size};
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        we = 1'b1;
        waddr = commit_addr[AW-1:0];
        wdata = {1'b1, commit_size};
        state_next = res_moved ? S_RELEASE : S_DONE;
      end
      S_RELEASE: begin
        we = 1'b1;
        waddr = hdr;
        wdata = {1'b0, old};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      clr <= clr_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mode_rsz <= mode_rsz_next;
    act <= act_next;
    req <= req_next;
    addr <= addr_next;
    need <= need_next;
    off <= off_next;
    cur <= cur_next;
    sum <= sum_next;
    old <= old_next;
    hdr <= hdr_next;
    do_split <= do_split_next;
    split_addr <= split_addr_next;
    split_size <= split_size_next;
    commit_addr <= commit_addr_next;
    commit_size <= commit_size_next;
    res_grant <= res_grant_next;
    res_status <= res_status_next;
    res_moved <= res_moved_next;
    res_copy <= res_copy_next;
    if (out_load) begin
      m_tdata <= {4'b0, res_copy, res_moved, res_status, res_grant};
    end
  end

  `ASSERT_ALWAYS(a_state_onehot, $onehot(state), "state not one-hot")
  `ASSERT_IMPLIES(a_valid_from_done, $rose(m_tvalid), $past(state == S_DONE), "result not from done")
  `ASSERT_IMPLIES(a_moved_ok, m_tvalid && m_tdata[18], m_tdata[17:16] == ST_OK, "moved with error")
  `ASSERT_IMPLIES(a_no_write_idle, state == S_IDLE, !we, "header write while idle")

endmodule
